// ===== rtl/awb_pkg.sv =====
package awb_pkg;

  // Defaults for the top-level parameters.
  localparam int ADC_BITS_DEF      = 12;
  localparam int FULL_SCALE_MV_DEF = 3300;

  // Fixed widths of the item fields.
  localparam int FS_W     = 12;  // full-scale millivolts fit in 12 bits
  localparam int Q_FRAC   = 4;   // fraction bits of a voltage
  localparam int VOLT_W   = 16;  // Q12.4 millivolts
  localparam int STATUS_W = 2;

  // One lane for each attenuation step of the autorange set.
  localparam int LANES = 4;

  // Pipeline depths, used for the latency figure.
  localparam int LANE_STAGES  = 3;
  localparam int MERGE_STAGES = 4;
  localparam int LATENCY      = LANE_STAGES + MERGE_STAGES + VOLT_W;

  // Status codes.
  localparam logic [STATUS_W-1:0] ST_OK     = 2'd0;
  localparam logic [STATUS_W-1:0] ST_FAILED = 2'd1;
  localparam logic [STATUS_W-1:0] ST_ZERO   = 2'd2;

  // Control that travels alongside the payload into the divider.
  typedef struct packed {
    logic                vld;
    logic [STATUS_W-1:0] status;
  } blend_ctl_t;

endpackage

// ===== rtl/adc_autorange_weighted_blend.sv =====
// Blends one autorange set of four ADC readings (12, 6, 2.5 and 0 dB
// attenuation) into a single weighted mean voltage in millivolts, Q12.4.
// An item is taken at every clock edge where start is high and busy is low;
// busy is high only while rst is asserted, so a new item may be given on
// every cycle. Each item yields exactly one result, shown on blended_voltage
// and status for one cycle with done high, after the item has passed through
// the per-reading lanes, the merging stage and the pipelined divider, which
// gives one quotient bit per stage. The result cannot be held off, so the
// receiver must capture it in the cycle that done is high. The calibration_present
// register is written through cfg_write and cfg_wdata and should only be
// changed while no item is in flight.
module adc_autorange_weighted_blend
  import awb_pkg::*;
#(
  parameter int ADC_BITS      = ADC_BITS_DEF,
  parameter int FULL_SCALE_MV = FULL_SCALE_MV_DEF
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  output logic                busy,
  input  logic                cfg_write,
  input  logic                cfg_wdata,
  input  logic [ADC_BITS:0]   raw_db12,
  input  logic [VOLT_W-1:0]   volts_db12,
  input  logic [ADC_BITS:0]   raw_db6,
  input  logic [VOLT_W-1:0]   volts_db6,
  input  logic [ADC_BITS:0]   raw_db2p5,
  input  logic [VOLT_W-1:0]   volts_db2p5,
  input  logic [ADC_BITS:0]   raw_db0,
  input  logic [VOLT_W-1:0]   volts_db0,
  output logic                done,
  output logic [VOLT_W-1:0]   blended_voltage,
  output logic [STATUS_W-1:0] status
);

  localparam int N  = ADC_BITS;
  localparam int DW = N + VOLT_W + 2;
  localparam int SW = N + 2;

  // The only configuration register. When clear, each voltage is derived
  // from the raw code by linear scaling to the full-scale voltage.
  logic calibration_present;

  always_ff @(posedge clk) begin
    if (rst) begin
      calibration_present <= 1'b0;
    end else if (cfg_write) begin
      calibration_present <= cfg_wdata;
    end
  end

  // The pipeline never stalls, so the block only refuses items in reset.
  assign busy = rst;

  logic accept;
  assign accept = start & ~busy;

  // Valid bits that follow the items through the lanes.
  logic [LANE_STAGES-1:0] lane_vld;

  always_ff @(posedge clk) begin
    if (rst) begin
      lane_vld <= '0;
    end else begin
      lane_vld <= {lane_vld[LANE_STAGES-2:0], accept};
    end
  end

  // Lane order follows the autorange order: 12 dB first, 0 dB last.
  logic [N:0]        raw_a   [LANES];
  logic [VOLT_W-1:0] volts_a [LANES];
  logic [LANES-1:0]  lane_fail;
  logic [N-1:0]      lane_code [LANES];
  logic [VOLT_W-1:0] lane_volt [LANES];

  assign raw_a[0]   = raw_db12;
  assign raw_a[1]   = raw_db6;
  assign raw_a[2]   = raw_db2p5;
  assign raw_a[3]   = raw_db0;
  assign volts_a[0] = volts_db12;
  assign volts_a[1] = volts_db6;
  assign volts_a[2] = volts_db2p5;
  assign volts_a[3] = volts_db0;

  for (genvar i = 0; i < LANES; i++) begin : g_lane
    awb_lane #(
      .ADC_BITS      (ADC_BITS),
      .FULL_SCALE_MV (FULL_SCALE_MV)
    ) u_lane (
      .clk   (clk),
      .cal   (calibration_present),
      .raw   (raw_a[i]),
      .volts (volts_a[i]),
      .fail  (lane_fail[i]),
      .code  (lane_code[i]),
      .volt  (lane_volt[i])
    );
  end

  // The merging stage decides which readings are in use, forms the
  // weights and the weighted sum, and sets the status.
  blend_ctl_t    merge_ctl;
  logic [DW-1:0] merge_dividend;
  logic [SW-1:0] merge_divisor;

  awb_merge #(
    .ADC_BITS (ADC_BITS)
  ) u_merge (
    .clk      (clk),
    .rst      (rst),
    .in_vld   (lane_vld[LANE_STAGES-1]),
    .fail     (lane_fail),
    .code     (lane_code),
    .volt     (lane_volt),
    .ctl      (merge_ctl),
    .dividend (merge_dividend),
    .divisor  (merge_divisor)
  );

  blend_ctl_t        div_ctl;
  logic [VOLT_W-1:0] div_quot;

  awb_div #(
    .DIVIDEND_W (DW),
    .DIVISOR_W  (SW),
    .QUOT_W     (VOLT_W)
  ) u_div (
    .clk      (clk),
    .rst      (rst),
    .in_ctl   (merge_ctl),
    .dividend (merge_dividend),
    .divisor  (merge_divisor),
    .out_ctl  (div_ctl),
    .quotient (div_quot)
  );

  // Any error forces the voltage to zero.
  assign done            = div_ctl.vld;
  assign status          = div_ctl.status;
  assign blended_voltage = (div_ctl.status == ST_OK) ? div_quot : '0;

endmodule

// ===== rtl/awb_lane.sv =====
module awb_lane
  import awb_pkg::*;
#(
  parameter int ADC_BITS      = ADC_BITS_DEF,
  parameter int FULL_SCALE_MV = FULL_SCALE_MV_DEF
) (
  input  logic                clk,
  input  logic                cal,
  input  logic [ADC_BITS:0]   raw,
  input  logic [VOLT_W-1:0]   volts,
  output logic                fail,
  output logic [ADC_BITS-1:0] code,
  output logic [VOLT_W-1:0]   volt
);

  localparam int N    = ADC_BITS;
  localparam int PW   = N + FS_W;
  localparam int W0   = PW + Q_FRAC;
  localparam int QW   = VOLT_W + 1;
  localparam logic [FS_W-1:0] FS     = FS_W'(FULL_SCALE_MV);
  localparam logic [N-1:0]    FULL   = '1;
  localparam logic [W0-1:0]   MASK   = W0'(FULL);
  localparam logic [W0-1:0]   ROUNDH = W0'(FULL >> 1);

  // Stage 1: decode and scale by the full-scale voltage.
  logic          fail1;
  logic [N-1:0]  code1;
  logic [VOLT_W-1:0] volts1;
  logic          cal1;
  logic [PW-1:0] prod1;

  always_ff @(posedge clk) begin
    fail1  <= raw[N];
    code1  <= raw[N-1:0];
    volts1 <= volts;
    cal1   <= cal;
    prod1  <= PW'(raw[N-1:0]) * PW'(FS);
  end

  // Division by the full code 2^N - 1 is done by folding the high part
  // back onto the low part: x = h*2^N + l = h*(2^N - 1) + h + l.
  logic [W0-1:0] s0, s_a, s2_next;
  logic [QW-1:0] q_a, q2_next;

  always_comb begin
    s0  = {prod1, {Q_FRAC{1'b0}}} + ROUNDH;
    s_a = s0;
    q_a = '0;
    for (int i = 0; i < 2; i++) begin
      q_a = q_a + QW'(s_a >> N);
      s_a = (s_a >> N) + (s_a & MASK);
    end
    s2_next = s_a;
    q2_next = q_a;
  end

  // Stage 2.
  logic          fail2;
  logic [N-1:0]  code2;
  logic [VOLT_W-1:0] volts2;
  logic          cal2;
  logic [W0-1:0] s2;
  logic [QW-1:0] q2;

  always_ff @(posedge clk) begin
    fail2  <= fail1;
    code2  <= code1;
    volts2 <= volts1;
    cal2   <= cal1;
    s2     <= s2_next;
    q2     <= q2_next;
  end

  // Two more folds leave a remainder below twice the divisor.
  logic [W0-1:0] s_b;
  logic [QW-1:0] q_b;
  logic [VOLT_W-1:0] volt_next;

  always_comb begin
    s_b = s2;
    q_b = q2;
    for (int i = 0; i < 2; i++) begin
      q_b = q_b + QW'(s_b >> N);
      s_b = (s_b >> N) + (s_b & MASK);
    end
    if (s_b >= MASK) begin
      q_b = q_b + QW'(1);
    end
    volt_next = cal2 ? volts2 : q_b[VOLT_W-1:0];
  end

  // Stage 3.
  always_ff @(posedge clk) begin
    fail <= fail2;
    code <= code2;
    volt <= volt_next;
  end

endmodule

// ===== rtl/awb_merge.sv =====
module awb_merge
  import awb_pkg::*;
#(
  parameter int ADC_BITS = ADC_BITS_DEF
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_vld,
  input  logic [LANES-1:0]    fail,
  input  logic [ADC_BITS-1:0] code [LANES],
  input  logic [VOLT_W-1:0]   volt [LANES],
  output blend_ctl_t          ctl,
  output logic [ADC_BITS+VOLT_W+1:0] dividend,
  output logic [ADC_BITS+1:0] divisor
);

  localparam int N  = ADC_BITS;
  localparam int PW = VOLT_W + N;
  localparam int SW = N + 2;
  localparam int DW = PW + 2;
  localparam logic [N-1:0] FULL = '1;
  localparam logic [N-1:0] HALF = {1'b1, {(N-1){1'b0}}};

  // Stage 1: which readings are in use, and the weights.
  logic [LANES-1:0]  use_r;
  logic              err_next;
  logic [N-1:0]      c   [LANES];
  logic [N-1:0]      w_next [LANES];
  logic [VOLT_W-1:0] v_next [LANES];
  logic [N-1:0]      dist1, dist2, tail;

  always_comb begin
    use_r[0] = 1'b1;
    for (int i = 1; i < LANES; i++) begin
      use_r[i] = use_r[i-1] & ~fail[i-1] & (code[i-1] != FULL);
    end
    err_next = |(use_r & fail);
    for (int i = 0; i < LANES; i++) begin
      c[i]      = use_r[i] ? code[i] : FULL;
      v_next[i] = use_r[i] ? volt[i] : '0;
    end
    dist1 = (c[1] >= HALF) ? c[1] - HALF : HALF - c[1];
    dist2 = (c[2] >= HALF) ? c[2] - HALF : HALF - c[2];
    tail  = FULL - c[3];
    w_next[0] = (c[0] < HALF) ? c[0] : HALF;
    w_next[1] = HALF - dist1;
    w_next[2] = HALF - dist2;
    w_next[3] = (tail < HALF) ? tail : HALF;
  end

  logic              vld1, vld2, vld3;
  logic              err1, err2, err3;
  logic [N-1:0]      w1 [LANES];
  logic [VOLT_W-1:0] v1 [LANES];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld1 <= 1'b0;
      vld2 <= 1'b0;
      vld3 <= 1'b0;
    end else begin
      vld1 <= in_vld;
      vld2 <= vld1;
      vld3 <= vld2;
    end
  end

  always_ff @(posedge clk) begin
    err1 <= err_next;
    w1   <= w_next;
    v1   <= v_next;
  end

  // Stage 2: one product per lane and the weight sum.
  logic [PW-1:0] prod2 [LANES];
  logic [SW-1:0] wsum2;

  always_ff @(posedge clk) begin
    err2 <= err1;
    for (int i = 0; i < LANES; i++) begin
      prod2[i] <= PW'(v1[i]) * PW'(w1[i]);
    end
    wsum2 <= SW'(w1[0]) + SW'(w1[1]) + SW'(w1[2]) + SW'(w1[3]);
  end

  // Stage 3: pair sums.
  logic [PW:0]   p01, p23;
  logic [SW-1:0] wsum3;

  always_ff @(posedge clk) begin
    err3  <= err2;
    p01   <= (PW+1)'(prod2[0]) + (PW+1)'(prod2[1]);
    p23   <= (PW+1)'(prod2[2]) + (PW+1)'(prod2[3]);
    wsum3 <= wsum2;
  end

  // Stage 4: total with half the divisor added for rounding, and status.
  logic [STATUS_W-1:0] status_next;

  always_comb begin
    priority if (err3) begin
      status_next = ST_FAILED;
    end else if (wsum3 == '0) begin
      status_next = ST_ZERO;
    end else begin
      status_next = ST_OK;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ctl.vld <= 1'b0;
    end else begin
      ctl.vld <= vld3;
    end
  end

  always_ff @(posedge clk) begin
    ctl.status <= status_next;
    dividend   <= DW'(p01) + DW'(p23) + DW'(wsum3 >> 1);
    divisor    <= wsum3;
  end

endmodule

// ===== rtl/awb_div.sv =====
module awb_div
  import awb_pkg::*;
#(
  parameter int DIVIDEND_W = 30,
  parameter int DIVISOR_W  = 14,
  parameter int QUOT_W     = VOLT_W
) (
  input  logic                  clk,
  input  logic                  rst,
  input  blend_ctl_t            in_ctl,
  input  logic [DIVIDEND_W-1:0] dividend,
  input  logic [DIVISOR_W-1:0]  divisor,
  output blend_ctl_t            out_ctl,
  output logic [QUOT_W-1:0]     quotient
);

  // Restoring division, one quotient bit per stage, most significant first.
  blend_ctl_t            ctl_s [QUOT_W+1];
  logic [DIVIDEND_W-1:0] rem_s [QUOT_W+1];
  logic [DIVISOR_W-1:0]  d_s   [QUOT_W+1];
  logic [QUOT_W-1:0]     q_s   [QUOT_W+1];

  assign ctl_s[0] = in_ctl;
  assign rem_s[0] = dividend;
  assign d_s[0]   = divisor;
  assign q_s[0]   = '0;

  for (genvar j = 0; j < QUOT_W; j++) begin : g_stage
    localparam int K = QUOT_W - 1 - j;
    logic [DIVIDEND_W-1:0] trial;
    logic                  ge;

    assign trial = DIVIDEND_W'(d_s[j]) << K;
    assign ge    = (rem_s[j] >= trial);

    always_ff @(posedge clk) begin
      if (rst) begin
        ctl_s[j+1].vld <= 1'b0;
      end else begin
        ctl_s[j+1].vld <= ctl_s[j].vld;
      end
    end

    always_ff @(posedge clk) begin
      ctl_s[j+1].status <= ctl_s[j].status;
      d_s[j+1]          <= d_s[j];
      rem_s[j+1]        <= ge ? rem_s[j] - trial : rem_s[j];
      q_s[j+1]          <= q_s[j] | (ge ? QUOT_W'(1) << K : QUOT_W'(0));
    end
  end

  assign out_ctl  = ctl_s[QUOT_W];
  assign quotient = q_s[QUOT_W];

endmodule

// ===== rtl/awb_checker.sv =====
module awb_checker
  import awb_pkg::*;
(
  input logic                clk,
  input logic                rst,
  input logic                start,
  input logic                busy,
  input logic                done,
  input logic [VOLT_W-1:0]   blended_voltage,
  input logic [STATUS_W-1:0] status
);

  // Reset empties the pipeline.
  a_reset_flush: assert property (@(posedge clk) rst |=> !done)
    else $error("result strobe straight after reset");

  // Every item taken gives its result after the fixed latency.
  a_latency: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |-> ##LATENCY done)
    else $error("result missing after an accepted item");

  // No result appears without an item taken the same distance back.
  a_no_spurious: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(start && !busy, LATENCY))
    else $error("result without a matching item");

  // An error result carries a zero voltage.
  a_error_zero: assert property (@(posedge clk) disable iff (rst)
    (done && status != ST_OK) |-> blended_voltage == '0)
    else $error("error result with a non-zero voltage");

  a_status_code: assert property (@(posedge clk) disable iff (rst)
    done |-> (status == ST_OK || status == ST_FAILED || status == ST_ZERO))
    else $error("result with an undefined status");

endmodule

bind adc_autorange_weighted_blend awb_checker u_awb_checker (.*);

// ===== tb/awb_blend_checker.sv =====
`timescale 1ns / 1ps

// Watches the item and result channels of the blender, keeps its own copy
// of the calibration register, predicts every result and compares it.
module awb_blend_checker
  import awb_pkg::*;
#(
  parameter int ADC_BITS      = ADC_BITS_DEF,
  parameter int FULL_SCALE_MV = FULL_SCALE_MV_DEF
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  input  logic                busy,
  input  logic                cfg_write,
  input  logic                cfg_wdata,
  input  logic [ADC_BITS:0]   raw_db12,
  input  logic [VOLT_W-1:0]   volts_db12,
  input  logic [ADC_BITS:0]   raw_db6,
  input  logic [VOLT_W-1:0]   volts_db6,
  input  logic [ADC_BITS:0]   raw_db2p5,
  input  logic [VOLT_W-1:0]   volts_db2p5,
  input  logic [ADC_BITS:0]   raw_db0,
  input  logic [VOLT_W-1:0]   volts_db0,
  input  logic                done,
  input  logic [VOLT_W-1:0]   blended_voltage,
  input  logic [STATUS_W-1:0] status,
  output int                  fail_count,
  output int                  outstanding
);

  localparam longint unsigned FULL_CODE = (64'd1 << ADC_BITS) - 1;
  localparam longint unsigned HALF_CODE = 64'd1 << (ADC_BITS - 1);

  typedef struct packed {
    logic [VOLT_W-1:0]   mv;
    logic [STATUS_W-1:0] st;
  } blend_result_t;

  blend_result_t pending_blends[$];
  logic          cal_used;

  function automatic longint unsigned mid_weight(input longint unsigned code);
    longint unsigned span;
    span = (code >= HALF_CODE) ? code - HALF_CODE : HALF_CODE - code;
    return (span >= HALF_CODE) ? 64'd0 : HALF_CODE - span;
  endfunction

  // Walks the attenuation steps in order and stops after the first full code;
  // steps never reached stay at full code and 0 V.
  function automatic blend_result_t predict_blend(input logic [ADC_BITS:0] raw [4],
                                                  input logic [VOLT_W-1:0] mv [4],
                                                  input logic use_cal);
    longint unsigned code [4];
    longint unsigned volt [4];
    longint unsigned w [4];
    longint unsigned wsum;
    longint unsigned acc;
    blend_result_t   res;
    bit              stop;
    res  = '0;
    stop = 1'b0;
    for (int i = 0; i < 4; i++) begin
      code[i] = FULL_CODE;
      volt[i] = 0;
    end
    for (int i = 0; i < 4 && !stop; i++) begin
      if (raw[i][ADC_BITS]) begin
        res.st = ST_FAILED;
        return res;
      end
      code[i] = 64'(raw[i][ADC_BITS-1:0]);
      if (use_cal) begin
        volt[i] = 64'(mv[i]);
      end else begin
        volt[i] = (code[i] * FULL_SCALE_MV * (64'd1 << Q_FRAC) + FULL_CODE / 2) / FULL_CODE;
      end
      if (code[i] >= FULL_CODE) stop = 1'b1;
    end
    w[0] = (code[0] < HALF_CODE) ? code[0] : HALF_CODE;
    w[1] = mid_weight(code[1]);
    w[2] = mid_weight(code[2]);
    w[3] = ((FULL_CODE - code[3]) < HALF_CODE) ? FULL_CODE - code[3] : HALF_CODE;
    wsum = 0;
    acc  = 0;
    for (int i = 0; i < 4; i++) begin
      wsum += w[i];
      acc  += volt[i] * w[i];
    end
    if (wsum == 0) begin
      res.st = ST_ZERO;
      return res;
    end
    res.mv = VOLT_W'((acc + wsum / 2) / wsum);
    res.st = ST_OK;
    return res;
  endfunction

  task automatic report_mismatch(input string msg);
    $display("checker: %s (t=%0t)", msg, $time);
    fail_count++;
  endtask

  initial begin
    fail_count  = 0;
    outstanding = 0;
    cal_used    = 1'b0;
  end

  always @(posedge clk) begin
    logic [ADC_BITS:0] raw [4];
    logic [VOLT_W-1:0] mv [4];
    blend_result_t     want;
    if (rst) begin
      cal_used = 1'b0;
      pending_blends.delete();
    end else begin
      if (done !== 1'b0) begin
        if (pending_blends.size() == 0) begin
          report_mismatch($sformatf("result %0d/%0d with nothing outstanding",
                                    blended_voltage, status));
        end else begin
          want = pending_blends.pop_front();
          if (blended_voltage !== want.mv)
            report_mismatch($sformatf("blended_voltage %0d, wanted %0d",
                                      blended_voltage, want.mv));
          if (status !== want.st)
            report_mismatch($sformatf("status %0d, wanted %0d", status, want.st));
        end
      end
      if (cfg_write) cal_used = cfg_wdata;
      if (start && !busy) begin
        raw = '{raw_db12, raw_db6, raw_db2p5, raw_db0};
        mv  = '{volts_db12, volts_db6, volts_db2p5, volts_db0};
        pending_blends.push_back(predict_blend(raw, mv, cal_used));
      end
    end
    outstanding = pending_blends.size();
  end

endmodule

// ===== tb/adc_autorange_weighted_blend_tb.sv =====
`timescale 1ns / 1ps

// Stimulus and verdict for the autorange blender. The checker beside the
// block does all prediction and comparison; this module only produces items,
// writes the calibration register between phases and decides the outcome.
module adc_autorange_weighted_blend_tb
  import awb_pkg::*;
();

  localparam int ADC_BITS = ADC_BITS_DEF;
  localparam logic [ADC_BITS:0] RAW_FAIL  = '1;
  localparam logic [ADC_BITS:0] FULL_CODE = (ADC_BITS + 1)'((1 << ADC_BITS) - 1);
  localparam logic [ADC_BITS:0] HALF_CODE = (ADC_BITS + 1)'(1 << (ADC_BITS - 1));
  localparam logic [VOLT_W-1:0] VOLT_MAX  = '1;

  logic                clk;
  logic                rst;
  logic                start;
  logic                busy;
  logic                cfg_write;
  logic                cfg_wdata;
  logic [ADC_BITS:0]   raw_in [4];
  logic [VOLT_W-1:0]   volts_in [4];
  logic                done;
  logic [VOLT_W-1:0]   blended_voltage;
  logic [STATUS_W-1:0] status;
  int                  fail_count;
  int                  outstanding;

  adc_autorange_weighted_blend dut (
    .clk             (clk),
    .rst             (rst),
    .start           (start),
    .busy            (busy),
    .cfg_write       (cfg_write),
    .cfg_wdata       (cfg_wdata),
    .raw_db12        (raw_in[0]),
    .volts_db12      (volts_in[0]),
    .raw_db6         (raw_in[1]),
    .volts_db6       (volts_in[1]),
    .raw_db2p5       (raw_in[2]),
    .volts_db2p5     (volts_in[2]),
    .raw_db0         (raw_in[3]),
    .volts_db0       (volts_in[3]),
    .done            (done),
    .blended_voltage (blended_voltage),
    .status          (status)
  );

  awb_blend_checker chk (
    .clk             (clk),
    .rst             (rst),
    .start           (start),
    .busy            (busy),
    .cfg_write       (cfg_write),
    .cfg_wdata       (cfg_wdata),
    .raw_db12        (raw_in[0]),
    .volts_db12      (volts_in[0]),
    .raw_db6         (raw_in[1]),
    .volts_db6       (volts_in[1]),
    .raw_db2p5       (raw_in[2]),
    .volts_db2p5     (volts_in[2]),
    .raw_db0         (raw_in[3]),
    .volts_db0       (volts_in[3]),
    .done            (done),
    .blended_voltage (blended_voltage),
    .status          (status),
    .fail_count      (fail_count),
    .outstanding     (outstanding)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // A hung block must not keep the run going for ever. The time limit allows
  // well over the slowest correct run.
  initial begin
    #2000000;
    $display("tb: failure");
    $finish;
  end

  // Offers one item from the falling edge and holds it until an edge at which
  // the block is not busy. Start is left high, so that a following item can
  // go out on the very next cycle.
  task automatic send_set(input logic [ADC_BITS:0] r12, input logic [VOLT_W-1:0] v12,
                          input logic [ADC_BITS:0] r6, input logic [VOLT_W-1:0] v6,
                          input logic [ADC_BITS:0] r2p5, input logic [VOLT_W-1:0] v2p5,
                          input logic [ADC_BITS:0] r0, input logic [VOLT_W-1:0] v0);
    @(negedge clk);
    start       <= 1'b1;
    raw_in[0]   <= r12;
    volts_in[0] <= v12;
    raw_in[1]   <= r6;
    volts_in[1] <= v6;
    raw_in[2]   <= r2p5;
    volts_in[2] <= v2p5;
    raw_in[3]   <= r0;
    volts_in[3] <= v0;
    do @(posedge clk); while (busy);
  endtask

  task automatic idle(input int cycles);
    repeat (cycles) begin
      @(negedge clk);
      start <= 1'b0;
    end
  endtask

  // Stops sending and waits for every outstanding result, then lets the
  // pipeline run on, so that the block is truly empty.
  task automatic drain();
    idle(1);
    wait (outstanding == 0);
    repeat (LATENCY + 4) @(posedge clk);
  endtask

  task automatic write_calibration(input logic value);
    @(negedge clk);
    cfg_write <= 1'b1;
    cfg_wdata <= value;
    @(negedge clk);
    cfg_write <= 1'b0;
  endtask

  // Raw codes lean towards the interesting corners: failed reads (including
  // negative values other than minus one), full code, which ends the autorange
  // walk, zero, and codes next to zero, full code and the half-scale weight peak.
  function automatic logic [ADC_BITS:0] pick_raw();
    int k;
    k = $urandom_range(0, 99);
    if (k < 3) return RAW_FAIL;
    if (k < 5) return {1'b1, ADC_BITS'($urandom)};
    if (k < 12) return FULL_CODE;
    if (k < 15) return '0;
    if (k < 21) begin
      case ($urandom_range(0, 3))
        0: return HALF_CODE;
        1: return HALF_CODE - 1'b1;
        2: return 1;
        default: return FULL_CODE - 1'b1;
      endcase
    end
    return (ADC_BITS + 1)'($urandom_range(0, FULL_CODE));
  endfunction

  function automatic logic [VOLT_W-1:0] pick_volts();
    int k;
    k = $urandom_range(0, 19);
    if (k == 0) return '0;
    if (k == 1) return VOLT_MAX;
    return VOLT_W'($urandom);
  endfunction

  // Random items in bursts. A dense burst has no gaps inside it; a sparse
  // one drops start now and then so that pauses land on every pipeline phase.
  task automatic run_random(input int count);
    int  sent;
    int  burst;
    bit  sparse;
    sent = 0;
    while (sent < count) begin
      burst  = $urandom_range(1, 40);
      sparse = $urandom_range(0, 1);
      for (int i = 0; i < burst && sent < count; i++) begin
        send_set(pick_raw(), pick_volts(), pick_raw(), pick_volts(),
                 pick_raw(), pick_volts(), pick_raw(), pick_volts());
        sent++;
        if (sparse && $urandom_range(0, 2) == 0) idle($urandom_range(1, 4));
      end
      if ($urandom_range(0, 2) != 0) idle($urandom_range(1, 12));
    end
  endtask

  initial begin
    rst       = 1'b1;
    start     = 1'b0;
    cfg_write = 1'b0;
    cfg_wdata = 1'b0;
    for (int i = 0; i < 4; i++) begin
      raw_in[i]   = '0;
      volts_in[i] = '0;
    end
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed items with the linear scaling. The register is written even
    // though reset already cleared it.
    write_calibration(1'b0);
    // All zero: only the 0 dB reading carries weight.
    send_set('0, '0, '0, '0, '0, '0, '0, '0);
    // Weight sum zero: the three lower readings at zero and 0 dB at full code.
    send_set('0, '0, '0, '0, '0, '0, FULL_CODE, '0);
    // A failed read at each attenuation while still in use.
    send_set(RAW_FAIL, '0, 100, '0, 200, '0, 300, '0);
    send_set(10, '0, RAW_FAIL, '0, 200, '0, 300, '0);
    send_set(10, '0, 20, '0, RAW_FAIL, '0, 300, '0);
    send_set(10, '0, 20, '0, 30, '0, RAW_FAIL, '0);
    // Any negative code is a failure, not just minus one.
    send_set({1'b1, {ADC_BITS{1'b0}}}, '0, 5, '0, 5, '0, 5, '0);
    // A failure after a full code is never reached and is ignored.
    send_set(FULL_CODE, '0, RAW_FAIL, '0, RAW_FAIL, '0, RAW_FAIL, '0);
    send_set(HALF_CODE, '0, FULL_CODE, '0, RAW_FAIL, '0, 7, '0);
    send_set(HALF_CODE, '0, HALF_CODE, '0, FULL_CODE, '0, RAW_FAIL, '0);
    // Full codes everywhere, half-scale peaks and their neighbours.
    send_set(FULL_CODE, '0, FULL_CODE, '0, FULL_CODE, '0, FULL_CODE, '0);
    send_set(HALF_CODE, '0, HALF_CODE, '0, HALF_CODE, '0, HALF_CODE, '0);
    send_set(HALF_CODE - 1'b1, '0, HALF_CODE - 1'b1, '0, HALF_CODE + 1'b1, '0,
             HALF_CODE - 1'b1, '0);
    send_set(1, '0, 1, '0, FULL_CODE - 1'b1, '0, FULL_CODE - 1'b1, '0);
    send_set(FULL_CODE - 1'b1, '0, FULL_CODE - 1'b1, '0, FULL_CODE - 1'b1, '0, 1, '0);
    drain();

    // Directed items with calibrated voltages. Voltages of readings that are
    // never reached must make no difference.
    write_calibration(1'b1);
    send_set(HALF_CODE, VOLT_MAX, HALF_CODE, VOLT_MAX, HALF_CODE, VOLT_MAX, 0, VOLT_MAX);
    send_set(HALF_CODE, '0, HALF_CODE, '0, HALF_CODE, '0, 0, '0);
    send_set(1000, 16'h1234, FULL_CODE, 16'h8000, 5, VOLT_MAX, 5, VOLT_MAX);
    send_set(FULL_CODE, VOLT_MAX, 5, 16'h5555, 5, 16'hAAAA, 5, 16'hFFFF);
    send_set(3000, 16'hAAAA, 3000, 16'h5555, 1500, VOLT_MAX, 1000, '0);
    send_set('0, VOLT_MAX, '0, VOLT_MAX, '0, VOLT_MAX, FULL_CODE, VOLT_MAX);
    send_set(RAW_FAIL, VOLT_MAX, 1, 1, 1, 1, 1, 1);
    drain();

    // Random phases, alternating the register. Draining before each write
    // makes sure no item in flight sees the change.
    write_calibration(1'b0);
    run_random(400);
    drain();
    write_calibration(1'b1);
    run_random(400);
    drain();
    write_calibration(1'b0);
    run_random(225);
    drain();
    write_calibration(1'b1);
    run_random(225);
    drain();

    if (fail_count == 0 && outstanding == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
